// ===== design/assert_macros.svh =====
// Assertion helper macros for the frame handler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every edge outside of reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside of reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/mbrtu_pkg.sv =====
// -----------------------------------------------------------------------------
// Modbus RTU slave package
// Shared types, constants and the CRC step function.
// -----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int FRAME_BYTES  = 8;
  localparam int BUFFER_DEPTH = 16;
  localparam int REPLY_MAX    = 15;

  localparam logic [7:0]  DEFAULT_ADDR = 8'h23;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  FUNC_READ    = 8'h03;
  localparam logic [7:0]  FUNC_WRITE   = 8'h06;
  localparam logic [7:0]  EXC_FLAG     = 8'h80;
  localparam logic [15:0] REG_ADDR     = 16'h0010;
  localparam logic [7:0]  EXC_FUNC     = 8'h01;
  localparam logic [7:0]  EXC_ADDR     = 8'h02;
  localparam logic [7:0]  EXC_VALUE    = 8'h03;

  localparam logic [0:0] CFG_BOOT_ADDR = 1'b0;
  localparam logic [0:0] CFG_TIMEOUT   = 1'b1;
  localparam logic       OP_BYTE       = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [15:0] temperature_reading;
    logic [15:0] humidity_reading;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        last_byte;
    logic        led_on;
    logic [15:0] brightness;
    logic        address_changed;
    logic [7:0]  station_address_now;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_DECIDE,
    ST_BUILD,
    ST_SEND
  } state_t;

  function automatic logic [15:0] crc_bit(input logic [15:0] c);
    crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
  endfunction

endpackage

// ===== design/mbrtu_ram.sv =====
// -----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// -----------------------------------------------------------------------------
module mbrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/modbus_rtu_slave_frame_handler_top.sv =====
// -----------------------------------------------------------------------------
// Modbus RTU slave frame handler
// Buffers request bytes, handles a frame after line silence, streams replies.
// -----------------------------------------------------------------------------
// Channel  Direction  Handshake
// in_      input      in_valid / in_ready, payload in_data
// out_     output     out_valid / out_ready, payload out_data
// cfg_     input      cfg_we, cfg_index, cfg_wdata (no wait)
//
// A tick that ends the silence starts frame handling: the frame is loaded
// from the store, the CRC is shifted over six bytes one bit a cycle, and
// the reply is decided. Each reply byte before the CRC is run through the
// bit-serial CRC and is then held until its output transfer; the two CRC
// bytes follow one per cycle while the output is ready. The input is not
// ready during handling.
// Reset is synchronous, active low.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_rtu_slave_frame_handler_top #(
  parameter int BUFFER_DEPTH = mbrtu_pkg::BUFFER_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbrtu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbrtu_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  mbrtu_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          armed_r, armed_nxt;
  logic [15:0]   sil_r, sil_nxt;
  logic [15:0]   tmo_r;
  logic [7:0]    addr_r, addr_nxt;
  logic          led_r, led_nxt;
  logic [15:0]   bri_r, bri_nxt;
  logic [15:0]   temp_r, temp_nxt;
  logic [15:0]   hum_r, hum_nxt;

  logic [7:0]    fr_r [mbrtu_pkg::FRAME_BYTES];
  logic [7:0]    fr_nxt [mbrtu_pkg::FRAME_BYTES];
  logic [7:0]    rep_r [mbrtu_pkg::REPLY_MAX];
  logic [7:0]    rep_nxt [mbrtu_pkg::REPLY_MAX];
  logic [3:0]    rlen_r, rlen_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic          chg_r, chg_nxt;
  logic          ov_r, ov_nxt;
  logic [7:0]    txb_r, txb_nxt;
  logic          lastb_r, lastb_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  logic          in_fire, out_fire;
  logic [15:0]   start_w, value_w, sil_inc, reg_v;
  logic [16:0]   sum_w;
  logic [7:0]    crc_in;

  mbrtu_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state_r == mbrtu_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign start_w  = {fr_r[2], fr_r[3]};
  assign value_w  = {fr_r[4], fr_r[5]};
  assign sum_w    = {1'b0, start_w} + {1'b0, value_w};
  assign sil_inc  = (sil_r == 16'hFFFF) ? sil_r : sil_r + 16'd1;
  assign ram_we   = in_fire && (in_data.operation == mbrtu_pkg::OP_BYTE)
                    && (cnt_r < CW'(BUFFER_DEPTH));
  assign ram_waddr = cnt_r[AW-1:0];
  assign ram_raddr = AW'(idx_r);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    armed_nxt = armed_r;
    sil_nxt   = sil_r;
    addr_nxt  = addr_r;
    led_nxt   = led_r;
    bri_nxt   = bri_r;
    temp_nxt  = temp_r;
    hum_nxt   = hum_r;
    fr_nxt    = fr_r;
    rep_nxt   = rep_r;
    rlen_nxt  = rlen_r;
    idx_nxt   = idx_r;
    bit_nxt   = bit_r;
    crc_nxt   = crc_r;
    chg_nxt   = chg_r;
    ov_nxt    = ov_r;
    txb_nxt   = txb_r;
    lastb_nxt = lastb_r;
    reg_v     = 16'd0;
    crc_in    = 8'd0;
    case (state_r)
      mbrtu_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_data.operation == mbrtu_pkg::OP_BYTE) begin
            if (cnt_r < CW'(BUFFER_DEPTH)) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            if (cnt_r + CW'(1) >= CW'(mbrtu_pkg::FRAME_BYTES)) begin
              armed_nxt = 1'b1;
              sil_nxt   = 16'd0;
            end
          end else if (armed_r) begin
            sil_nxt = sil_inc;
            if (sil_inc >= tmo_r) begin
              armed_nxt = 1'b0;
              sil_nxt   = 16'd0;
              temp_nxt  = in_data.temperature_reading;
              hum_nxt   = in_data.humidity_reading;
              idx_nxt   = 4'd0;
              state_nxt = mbrtu_pkg::ST_LOAD;
            end
          end
        end
      end
      mbrtu_pkg::ST_LOAD: begin
        if (idx_r != 4'd0) begin
          fr_nxt[idx_r[2:0] - 3'd1] = ram_rdata;
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(mbrtu_pkg::FRAME_BYTES)) begin
          idx_nxt   = 4'd0;
          bit_nxt   = 3'd0;
          crc_nxt   = mbrtu_pkg::CRC_INIT;
          state_nxt = mbrtu_pkg::ST_CHECK;
        end
      end
      mbrtu_pkg::ST_CHECK: begin
        crc_in  = (bit_r == 3'd0) ? fr_r[idx_r[2:0]] : 8'd0;
        crc_nxt = mbrtu_pkg::crc_bit(crc_r ^ {8'd0, crc_in});
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          idx_nxt = idx_r + 4'd1;
          if (idx_r == 4'd5) begin
            state_nxt = mbrtu_pkg::ST_DECIDE;
          end
        end
      end
      mbrtu_pkg::ST_DECIDE: begin
        cnt_nxt   = '0;
        chg_nxt   = 1'b0;
        rep_nxt[0] = fr_r[0];
        rep_nxt[1] = fr_r[1] + mbrtu_pkg::EXC_FLAG;
        rlen_nxt  = 4'd3;
        state_nxt = mbrtu_pkg::ST_BUILD;
        if (fr_r[0] != addr_r) begin
          state_nxt = mbrtu_pkg::ST_IDLE;
        end else if (crc_r != {fr_r[7], fr_r[6]}) begin
          rep_nxt[2] = mbrtu_pkg::EXC_VALUE;
        end else if (fr_r[1] == mbrtu_pkg::FUNC_READ) begin
          if (start_w > 16'd4) begin
            rep_nxt[2] = mbrtu_pkg::EXC_ADDR;
          end else if (value_w == 16'd0 || sum_w > 17'd5) begin
            rep_nxt[2] = mbrtu_pkg::EXC_VALUE;
          end else begin
            rep_nxt[1] = fr_r[1];
            rep_nxt[2] = {value_w[6:0], 1'b0};
            for (int i = 0; i < 5; i++) begin
              case (3'(start_w[2:0] + 3'(i)))
                3'd1:    reg_v = {15'd0, led_r};
                3'd2:    reg_v = bri_r;
                3'd3:    reg_v = temp_r;
                3'd4:    reg_v = hum_r;
                default: reg_v = 16'd0;
              endcase
              if (16'(i) < value_w) begin
                rep_nxt[3 + 2*i] = reg_v[15:8];
                rep_nxt[4 + 2*i] = reg_v[7:0];
              end
            end
            rlen_nxt = 4'(3 + 2 * value_w[2:0]);
          end
        end else if (fr_r[1] == mbrtu_pkg::FUNC_WRITE) begin
          if (start_w > 16'd5 && start_w != mbrtu_pkg::REG_ADDR) begin
            rep_nxt[2] = mbrtu_pkg::EXC_ADDR;
          end else begin
            if (start_w == mbrtu_pkg::REG_ADDR) begin
              addr_nxt = fr_r[5];
              chg_nxt  = 1'b1;
            end
            if (start_w == 16'd1) begin
              led_nxt = (value_w == 16'd1);
            end
            if (start_w == 16'd2) begin
              bri_nxt = value_w;
            end
            rep_nxt[1] = fr_r[1];
            rep_nxt[2] = 8'd2;
            rep_nxt[3] = fr_r[4];
            rep_nxt[4] = fr_r[5];
            rlen_nxt   = 4'd5;
          end
        end else begin
          rep_nxt[2] = mbrtu_pkg::EXC_FUNC;
        end
        idx_nxt = 4'd0;
        bit_nxt = 3'd0;
        crc_nxt = mbrtu_pkg::CRC_INIT;
      end
      mbrtu_pkg::ST_BUILD: begin
        if (!ov_r) begin
          crc_in  = (bit_r == 3'd0) ? rep_r[idx_r] : 8'd0;
          crc_nxt = mbrtu_pkg::crc_bit(crc_r ^ {8'd0, crc_in});
          bit_nxt = bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            txb_nxt   = rep_r[idx_r];
            lastb_nxt = 1'b0;
            ov_nxt    = 1'b1;
            idx_nxt   = idx_r + 4'd1;
            if (idx_r + 4'd1 == rlen_r) begin
              state_nxt = mbrtu_pkg::ST_SEND;
            end
          end
        end else if (out_ready) begin
          ov_nxt = 1'b0;
        end
      end
      mbrtu_pkg::ST_SEND: begin
        if (ov_r && out_ready) begin
          ov_nxt = 1'b0;
        end
        if (!ov_r || out_ready) begin
          if (idx_r == rlen_r) begin
            txb_nxt   = crc_r[7:0];
            lastb_nxt = 1'b0;
            ov_nxt    = 1'b1;
            idx_nxt   = idx_r + 4'd1;
          end else if (idx_r == rlen_r + 4'd1) begin
            txb_nxt   = crc_r[15:8];
            lastb_nxt = 1'b1;
            ov_nxt    = 1'b1;
            idx_nxt   = idx_r + 4'd1;
          end else begin
            state_nxt = mbrtu_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = mbrtu_pkg::ST_IDLE;
    endcase
    if (cfg_we && cfg_index == mbrtu_pkg::CFG_BOOT_ADDR) begin
      addr_nxt = (cfg_wdata[7:0] == 8'd0) ? mbrtu_pkg::DEFAULT_ADDR : cfg_wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbrtu_pkg::ST_IDLE;
      cnt_r   <= '0;
      armed_r <= 1'b0;
      sil_r   <= 16'd0;
      tmo_r   <= 16'd50;
      addr_r  <= mbrtu_pkg::DEFAULT_ADDR;
      led_r   <= 1'b0;
      bri_r   <= 16'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
      sil_r   <= sil_nxt;
      addr_r  <= addr_nxt;
      led_r   <= led_nxt;
      bri_r   <= bri_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we && cfg_index == mbrtu_pkg::CFG_TIMEOUT) begin
        tmo_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    temp_r  <= temp_nxt;
    hum_r   <= hum_nxt;
    fr_r    <= fr_nxt;
    rep_r   <= rep_nxt;
    rlen_r  <= rlen_nxt;
    idx_r   <= idx_nxt;
    bit_r   <= bit_nxt;
    crc_r   <= crc_nxt;
    chg_r   <= chg_nxt;
    txb_r   <= txb_nxt;
    lastb_r <= lastb_nxt;
  end

  assign out_data.tx_byte             = txb_r;
  assign out_data.last_byte           = lastb_r;
  assign out_data.led_on              = led_r;
  assign out_data.brightness          = bri_r;
  assign out_data.address_changed     = chg_r;
  assign out_data.station_address_now = addr_r;

  `ASSERT_IMPL(a_no_in_busy, state_r != mbrtu_pkg::ST_IDLE, !in_ready)
  `ASSERT_IMPL(a_out_only_busy, out_valid, state_r == mbrtu_pkg::ST_BUILD || state_r == mbrtu_pkg::ST_SEND)
  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(BUFFER_DEPTH))
  `ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(txb_r))

endmodule

// ===== tb/mbrtu_reply_checker.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Modbus RTU reply checker
// Watches the byte/tick channel, the reply channel and the register port of
// the frame handler. It keeps its own copy of the frame store, silence timer,
// station address and LED settings, and builds each expected reply with its
// CRC. Every reply byte is compared field by field with the oldest one due.
// -----------------------------------------------------------------------------
module mbrtu_reply_checker
  import mbrtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [15:0] cfg_wdata,
  output int         fail_count,
  output int         pending,
  output int         bytes_seen,
  output int         replies_seen,
  output logic [7:0] station_now
);

  out_item_t   reply_due[$];
  logic [7:0]  store[BUFFER_DEPTH];
  int          held;
  logic        armed;
  logic [15:0] silence;
  logic [15:0] silence_limit;
  logic [7:0]  station;
  logic        led;
  logic [15:0] bright;

  function automatic logic [15:0] crc16(input logic [7:0] b[17], input int n);
    logic [15:0] c;
    c = CRC_INIT;
    for (int k = 0; k < n; k++) begin
      c = c ^ {8'h00, b[k]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic handle_request(input in_item_t it);
    logic [7:0]  r[17];
    logic [15:0] c, start, value, v;
    int          n;
    logic        changed;
    out_item_t   o;
    changed = 1'b0;
    n = 0;
    start = {store[2], store[3]};
    value = {store[4], store[5]};
    for (int k = 0; k < 17; k++) r[k] = 8'h00;
    for (int k = 0; k < 8; k++) r[k] = store[k];
    if (store[0] != station) return;
    r[0] = store[0];
    if (crc16(r, 6) != {store[7], store[6]}) begin
      r[1] = store[1] + EXC_FLAG; r[2] = EXC_VALUE; n = 3;
    end else if (store[1] == FUNC_READ) begin
      if (start > 16'd4) begin
        r[1] = store[1] + EXC_FLAG; r[2] = EXC_ADDR; n = 3;
      end else if (value < 16'd1 || ({16'd0, value} + start) > 32'd5) begin
        r[1] = store[1] + EXC_FLAG; r[2] = EXC_VALUE; n = 3;
      end else begin
        r[1] = FUNC_READ; r[2] = value[7:0] * 8'd2; n = 3;
        for (int i = 0; i < value; i++) begin
          case (start + i)
            1: v = {15'd0, led};
            2: v = bright;
            3: v = it.temperature_reading;
            4: v = it.humidity_reading;
            default: v = 16'd0;
          endcase
          r[n] = v[15:8]; r[n + 1] = v[7:0]; n += 2;
        end
      end
    end else if (store[1] == FUNC_WRITE) begin
      if (start == REG_ADDR) begin
        station = value[7:0]; changed = 1'b1;
      end
      if (start != REG_ADDR && start > 16'd5) begin
        r[1] = store[1] + EXC_FLAG; r[2] = EXC_ADDR; n = 3;
      end else begin
        if (start == 16'd1) led = (value == 16'd1);
        else if (start == 16'd2) bright = value;
        r[1] = FUNC_WRITE; r[2] = 8'd2; r[3] = value[15:8]; r[4] = value[7:0]; n = 5;
      end
    end else begin
      r[1] = store[1] + EXC_FLAG; r[2] = EXC_FUNC; n = 3;
    end
    c = crc16(r, n);
    r[n] = c[7:0]; r[n + 1] = c[15:8]; n += 2;
    for (int k = 0; k < n; k++) begin
      o.tx_byte = r[k];
      o.last_byte = (k == n - 1);
      o.led_on = led;
      o.brightness = bright;
      o.address_changed = changed;
      o.station_address_now = station;
      reply_due.push_back(o);
    end
    replies_seen++;
  endtask

  task automatic take_item(input in_item_t it);
    if (it.operation == OP_BYTE) begin
      if (held < BUFFER_DEPTH) begin
        store[held] = it.rx_byte;
        held++;
      end
      if (held >= FRAME_BYTES) begin
        armed = 1'b1; silence = 16'd0;
      end
    end else if (armed) begin
      if (silence != 16'hFFFF) silence++;
      if (silence >= silence_limit) begin
        armed = 1'b0; silence = 16'd0;
        handle_request(it);
        held = 0;
      end
    end
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (reply_due.size() == 0) begin
      $display("%0t: unexpected reply byte, expected none, actual %h", $time, got);
      fail_count++;
      return;
    end
    want = reply_due.pop_front();
    bytes_seen++;
    if (got.tx_byte !== want.tx_byte)
      $display("%0t: tx_byte expected %h actual %h", $time, want.tx_byte, got.tx_byte);
    if (got.last_byte !== want.last_byte)
      $display("%0t: last_byte expected %b actual %b", $time, want.last_byte, got.last_byte);
    if (got.led_on !== want.led_on)
      $display("%0t: led_on expected %b actual %b", $time, want.led_on, got.led_on);
    if (got.brightness !== want.brightness)
      $display("%0t: brightness expected %h actual %h", $time, want.brightness,
               got.brightness);
    if (got.address_changed !== want.address_changed)
      $display("%0t: address_changed expected %b actual %b", $time,
               want.address_changed, got.address_changed);
    if (got.station_address_now !== want.station_address_now)
      $display("%0t: station_address_now expected %h actual %h", $time,
               want.station_address_now, got.station_address_now);
    if (got !== want) fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    bytes_seen = 0;
    replies_seen = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      reply_due.delete();
      held = 0;
      armed = 1'b0;
      silence = 16'd0;
      silence_limit = 16'd50;
      station = DEFAULT_ADDR;
      led = 1'b0;
      bright = 16'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BOOT_ADDR)
          station = (cfg_wdata[7:0] == 8'd0) ? DEFAULT_ADDR : cfg_wdata[7:0];
        else
          silence_limit = cfg_wdata;
      end
      if (out_valid && out_ready) check_byte(out_data);
      if (in_valid && in_ready) take_item(in_data);
    end
    pending = reply_due.size();
    station_now = station;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Modbus RTU slave frame handler testbench
// Sends request frames, line noise and silence ticks to the handler under
// random flow control and register settings; the reply checker predicts and
// compares every reply byte.
// -----------------------------------------------------------------------------
module tb_top;
  import mbrtu_pkg::*;

  localparam int LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  int          fail_count, pending, bytes_seen, replies_seen;
  logic [7:0]  station_now;
  int          items, frames, cycles, hold_left, burst_left;
  bit          idle_on;
  logic [15:0] tick_limit;
  logic [7:0]  frm[8];

  modbus_rtu_slave_frame_handler_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mbrtu_reply_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .bytes_seen(bytes_seen),
    .replies_seen(replies_seen), .station_now(station_now)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** modbus_rtu_slave_frame_handler_top: FAILED **");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b1;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (burst_left > 0) begin
        out_ready = 1'b0;
        burst_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        burst_left = $urandom_range(0, 6);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic offer(input logic op, input logic [7:0] b);
    in_item_t it;
    it.operation = op;
    it.rx_byte = b;
    it.temperature_reading = 16'($urandom);
    it.humidity_reading = 16'($urandom);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_data = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items++;
  endtask

  task automatic ticks(input int n);
    for (int k = 0; k < n; k++) offer(1'b1, 8'($urandom));
  endtask

  task automatic make_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [15:0] start, input logic [15:0] value,
                            input bit bad_crc);
    logic [15:0] c;
    frm[0] = addr; frm[1] = func;
    frm[2] = start[15:8]; frm[3] = start[7:0];
    frm[4] = value[15:8]; frm[5] = value[7:0];
    c = CRC_INIT;
    for (int k = 0; k < 6; k++) begin
      c = c ^ {8'h00, frm[k]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    if (bad_crc) c = c ^ (16'd1 << $urandom_range(0, 15));
    frm[6] = c[7:0]; frm[7] = c[15:8];
  endtask

  task automatic send_request(input logic [7:0] addr, input logic [7:0] func,
                              input logic [15:0] start, input logic [15:0] value,
                              input bit bad_crc, input int extra);
    make_frame(addr, func, start, value, bad_crc);
    for (int k = 0; k < 8; k++) offer(1'b0, frm[k]);
    for (int k = 0; k < extra; k++) offer(1'b0, 8'($urandom));
    ticks(int'(tick_limit));
    frames++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_TIMEOUT) tick_limit = val;
  endtask

  task automatic random_request();
    logic [7:0]  addr, func;
    logic [15:0] start, value;
    addr = ($urandom_range(0, 9) < 8) ? station_now : 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: func = FUNC_READ;
      4, 5, 6:    func = FUNC_WRITE;
      default:    func = 8'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0:       start = REG_ADDR;
      1:       start = 16'($urandom);
      default: start = 16'($urandom_range(0, 6));
    endcase
    value = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
    send_request(addr, func, start, value, $urandom_range(0, 9) == 0,
                 ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 12)) : 0);
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BOOT_ADDR;
    cfg_wdata = 16'd0;
    rst_n = 1'b0;
    items = 0;
    frames = 0;
    cycles = 0;
    hold_left = 0;
    idle_on = 1'b0;
    tick_limit = 16'd50;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_reg(CFG_TIMEOUT, 16'd1);
    send_request(station_now, FUNC_READ, 16'd0, 16'd5, 0, 0);
    send_request(station_now, FUNC_WRITE, 16'd1, 16'd1, 0, 0);
    send_request(station_now, FUNC_WRITE, 16'd2, 16'hFFFF, 0, 0);
    send_request(station_now, FUNC_READ, 16'd1, 16'd4, 0, 0);
    send_request(station_now, FUNC_READ, 16'd5, 16'd1, 0, 0);
    send_request(station_now, FUNC_READ, 16'd2, 16'd0, 0, 0);
    send_request(station_now, FUNC_READ, 16'd3, 16'd3, 0, 0);
    send_request(station_now, FUNC_WRITE, 16'd7, 16'd1, 0, 0);
    send_request(station_now, FUNC_WRITE, 16'd5, 16'h1234, 0, 8);
    send_request(station_now, 8'h85, 16'd0, 16'd1, 0, 0);
    send_request(station_now, FUNC_READ, 16'd0, 16'd1, 1, 0);
    send_request(station_now ^ 8'h01, FUNC_READ, 16'd0, 16'd1, 0, 0);
    ticks(2);
    for (int k = 0; k < 5; k++) offer(1'b0, 8'($urandom));
    ticks(3);
    send_request(station_now, FUNC_WRITE, REG_ADDR, 16'hFF00, 0, 0);
    send_request(8'h00, FUNC_READ, 16'd4, 16'd1, 0, 0);
    settle();

    write_reg(CFG_BOOT_ADDR, 16'h00FF);
    write_reg(CFG_TIMEOUT, 16'd20);
    send_request(8'hFF, FUNC_READ, 16'd3, 16'd2, 0, 0);
    settle();
    write_reg(CFG_BOOT_ADDR, 16'h0000);

    idle_on = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 4)));
      if (phase == 1) write_reg(CFG_BOOT_ADDR, 16'($urandom_range(1, 255)));
      if (phase == 2) hold_left = 800;
      if (phase == 3) idle_on = 1'b0;
      while (items < 210 + 40 * phase) begin
        if ($urandom_range(0, 5) == 0) begin
          for (int k = $urandom_range(1, 4); k > 0; k--)
            offer(1'($urandom_range(0, 1)), 8'($urandom));
        end else begin
          random_request();
        end
      end
      settle();
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("Sent %0d items in %0d request frames; checked %0d reply bytes in %0d replies.",
             items, frames, bytes_seen, replies_seen);
    if (fail_count == 0) begin
      $display("** modbus_rtu_slave_frame_handler_top: PASSED **");
    end else begin
      $display("** modbus_rtu_slave_frame_handler_top: FAILED **");
    end
    $finish;
  end

endmodule
